// ===== design/vsta_pkg.sv =====
package vsta_pkg;

  // default geometry
  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 16;

  // field widths fixed by the interface
  localparam int AMT_W = 16;
  localparam int THR_W = 16;

  // per-axis offset magnitude limit is 2^CAP_SHIFT
  localparam int CAP_SHIFT = 40;

  typedef enum logic [1:0] {
    MODE_TOWARD = 2'd0,
    MODE_AWAY   = 2'd1,
    MODE_SEEK   = 2'd2
  } mode_e;

endpackage

// ===== design/vsta_sqrt_cell.sv =====
// one root bit of the distance square root, radicand is rad << 2*FRAC_BITS
module vsta_sqrt_cell #(
  parameter int IDX       = 0,
  parameter int DW        = 41,
  parameter int SW        = 50,
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [DW+1:0]     rem_i,
  input  logic [DW-1:0]     root_i,
  input  logic [SW-1:0]     rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [DW+1:0]     rem_o,
  output logic [DW-1:0]     root_o,
  output logic [SW-1:0]     rad_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int K  = DW - 1 - IDX;
  localparam int LO = 2 * K - 2 * FRAC_BITS;

  logic [1:0]    pair;
  logic [DW+1:0] rem_sh;
  logic [DW+1:0] trial;
  logic          ge;
  logic          vld_q;
  logic [DW+1:0] rem_q, rem_d;
  logic [DW-1:0] root_q, root_d;
  logic [SW-1:0] rad_q;
  logic [SIDE_W-1:0] side_q;

  // next two radicand bits, the low fraction pairs are zero
  generate
    if (LO >= 0) begin : g_pair
      assign pair = rad_i[LO+1:LO];
    end else begin : g_zero
      assign pair = 2'b00;
    end
  endgenerate

  // restoring square root step
  always_comb begin
    rem_sh = {rem_i[DW-1:0], pair};
    trial  = {root_i, 2'b01};
    ge     = (rem_sh >= trial);
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
    root_d = {root_i[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    rad_q  <= rad_i;
    side_q <= side_i;
  end

  assign vld_o  = vld_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;
  assign side_o = side_q;

endmodule

// ===== design/vsta_div_cell.sv =====
// one quotient bit for all three axes, numerator fed msb first
module vsta_div_cell #(
  parameter int IDX    = 0,
  parameter int DW     = 41,
  parameter int NW     = 67,
  parameter int SIDE_W = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  logic [DW-1:0]        dvs_i,
  input  logic [2:0][NW-1:0]   num_i,
  input  logic [2:0][DW-1:0]   rem_i,
  input  logic [2:0][NW-1:0]   quo_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 vld_o,
  output logic [DW-1:0]        dvs_o,
  output logic [2:0][NW-1:0]   num_o,
  output logic [2:0][DW-1:0]   rem_o,
  output logic [2:0][NW-1:0]   quo_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int BIT = NW - 1 - IDX;

  logic                vld_q;
  logic [DW-1:0]       dvs_q;
  logic [2:0][NW-1:0]  num_q;
  logic [2:0][DW-1:0]  rem_q, rem_d;
  logic [2:0][NW-1:0]  quo_q, quo_d;
  logic [SIDE_W-1:0]   side_q;

  // restoring division step per lane
  always_comb begin
    logic [DW:0] sh;
    logic        ge;
    for (int k = 0; k < 3; k++) begin
      sh       = {rem_i[k], num_i[k][BIT]};
      ge       = (sh >= {1'b0, dvs_i});
      sh       = ge ? (sh - {1'b0, dvs_i}) : sh;
      rem_d[k] = sh[DW-1:0];
      quo_d[k] = {quo_i[k][NW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q  <= dvs_i;
    num_q  <= num_i;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    side_q <= side_i;
  end

  assign vld_o  = vld_q;
  assign dvs_o  = dvs_q;
  assign num_o  = num_q;
  assign rem_o  = rem_q;
  assign quo_o  = quo_q;
  assign side_o = side_q;

endmodule

// ===== design/vector_step_toward_away.sv =====
// Position step unit: takes one item per clock whenever start_i is high (busy_o is
// always low) and returns each result on done_o, in order. The pipeline runs the square
// root row (one root bit per cell) followed by the divider row (one quotient bit per
// cell, three axes side by side). Results cannot be held off; the receiver must take
// done_o when it appears.
module vector_step_toward_away import vsta_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         cfg_we_i,
  input  logic [THR_W-1:0]             cfg_wdata_i,
  input  logic [1:0]                   mode_i,
  input  logic signed [COORD_BITS-1:0] self_x_i,
  input  logic signed [COORD_BITS-1:0] self_y_i,
  input  logic signed [COORD_BITS-1:0] self_z_i,
  input  logic signed [COORD_BITS-1:0] goal_x_i,
  input  logic signed [COORD_BITS-1:0] goal_y_i,
  input  logic signed [COORD_BITS-1:0] goal_z_i,
  input  logic [AMT_W-1:0]             amount_i,
  output logic                         done_o,
  output logic                         moved_o,
  output logic signed [COORD_BITS-1:0] next_x_o,
  output logic signed [COORD_BITS-1:0] next_y_o,
  output logic signed [COORD_BITS-1:0] next_z_o,
  output logic [THR_W-1:0]             visit_limit_o
);

  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1 + FRAC_BITS;
  localparam int SW   = 2 * CW + 2;
  localparam int STW  = (CW + 2 > AMT_W) ? CW + 2 : AMT_W;
  localparam int NW   = CW + STW + FRAC_BITS + 1;
  localparam int QW   = (NW > CAP_SHIFT + 1) ? NW : CAP_SHIFT + 1;
  localparam int AW   = CAP_SHIFT + 3;
  localparam int CMPW = (SW > 2 * AMT_W) ? SW : 2 * AMT_W;
  localparam int SQW  = (2 * STW > SW) ? 2 * STW : SW;
  localparam int SQ_SIDE_W = 2 + AMT_W + 2 + 3 + 9 * CW;
  localparam int DV_SIDE_W = THR_W + 2 + 3 + 6 * CW;

  logic [THR_W-1:0] thr_q;

  // stage a: input registers
  logic               a_vld_q;
  logic [1:0]         a_mode_q;
  logic [2:0][CW-1:0] a_s_q, a_g_q;
  logic [AMT_W-1:0]   a_amt_q;

  // stage b: differences and squares
  logic [2:0][CW-1:0] b_mag_d;
  logic [2:0]         b_sgn_d;
  logic               b_vld_q;
  logic [1:0]         b_mode_q;
  logic [2:0][CW-1:0] b_s_q, b_g_q, b_mag_q;
  logic [2:0]         b_sgn_q;
  logic [2:0][2*CW-1:0] b_sq_q;
  logic [2*AMT_W-1:0] b_r2_q;
  logic [AMT_W-1:0]   b_amt_q;

  // square root row
  logic                 sq_vld  [0:DW];
  logic [DW+1:0]        sq_rem  [0:DW];
  logic [DW-1:0]        sq_root [0:DW];
  logic [SW-1:0]        sq_rad  [0:DW];
  logic [SQ_SIDE_W-1:0] sq_side [0:DW];

  logic [SW-1:0]        c_sum;
  logic                 c_vld_q;
  logic [SW-1:0]        c_sum_q;
  logic [SQ_SIDE_W-1:0] c_side_q;

  // stage e: step length
  logic [1:0]         e_mode;
  logic [AMT_W-1:0]   e_amt;
  logic               e_far, e_nz;
  logic [2:0]         e_sgn;
  logic [2:0][CW-1:0] e_mag, e_g, e_s;
  logic [DW:0]        e_rnd;
  logic [STW:0]       e_rd, e_ap1;
  logic [STW-1:0]     e_step_d, e_sm1;
  logic               e_moved_d;
  logic [THR_W-1:0]   e_vlim_d;

  logic               e_vld_q, e_moved_q, e_away_q;
  logic [STW-1:0]     e_step_q;
  logic [DW-1:0]      e_dist_q;
  logic [SW-1:0]      e_sum_q;
  logic [THR_W-1:0]   e_vlim_q;
  logic [2:0]         e_sgn_q;
  logic [2:0][CW-1:0] e_mag_q, e_s_q, e_g_q;

  // stage f: products
  logic [2*STW-1:0]       f_ss;
  logic                   f_vld_q, f_moved_q, f_reach_q;
  logic [DW-1:0]          f_dist_q;
  logic [THR_W-1:0]       f_vlim_q;
  logic [2:0]             f_sgn_q;
  logic [2:0][CW-1:0]     f_s_q, f_g_q;
  logic [2:0][CW+STW-1:0] f_prod_q;

  // divider row
  logic                 dv_vld  [0:NW];
  logic [DW-1:0]        dv_dvs  [0:NW];
  logic [2:0][NW-1:0]   dv_num  [0:NW];
  logic [2:0][DW-1:0]   dv_rem  [0:NW];
  logic [2:0][NW-1:0]   dv_quo  [0:NW];
  logic [DV_SIDE_W-1:0] dv_side [0:NW];

  logic [2:0][NW-1:0]   g_num;

  // final stage
  logic [THR_W-1:0]   h_vlim;
  logic               h_moved, h_reach;
  logic [2:0]         h_sgn;
  logic [2:0][CW-1:0] h_s, h_g, h_nxt;

  logic               done_q, moved_q;
  logic [2:0][CW-1:0] nxt_q;
  logic [THR_W-1:0]   vlim_q;

  assign busy_o = 1'b0;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // control valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      a_vld_q <= start_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      e_vld_q <= sq_vld[DW];
      f_vld_q <= e_vld_q;
      done_q  <= dv_vld[NW];
    end
  end

  // input transfer
  always_ff @(posedge clk_i) begin
    a_mode_q <= mode_i;
    a_s_q    <= {self_z_i, self_y_i, self_x_i};
    a_g_q    <= {goal_z_i, goal_y_i, goal_x_i};
    a_amt_q  <= amount_i;
  end

  // direction per axis
  always_comb begin
    logic [CW:0] ds, dg, df, mg;
    for (int k = 0; k < 3; k++) begin
      ds = {a_s_q[k][CW-1], a_s_q[k]};
      dg = {a_g_q[k][CW-1], a_g_q[k]};
      df = (a_mode_q == MODE_AWAY) ? (ds - dg) : (dg - ds);
      mg = df[CW] ? (-df) : df;
      b_sgn_d[k] = df[CW];
      b_mag_d[k] = mg[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    b_mode_q <= a_mode_q;
    b_s_q    <= a_s_q;
    b_g_q    <= a_g_q;
    b_amt_q  <= a_amt_q;
    b_mag_q  <= b_mag_d;
    b_sgn_q  <= b_sgn_d;
    b_r2_q   <= a_amt_q * a_amt_q;
    for (int k = 0; k < 3; k++) begin
      b_sq_q[k] <= b_mag_d[k] * b_mag_d[k];
    end
  end

  // squared distance and standoff compare
  assign c_sum = SW'(b_sq_q[0]) + SW'(b_sq_q[1]) + SW'(b_sq_q[2]);

  always_ff @(posedge clk_i) begin
    c_sum_q  <= c_sum;
    c_side_q <= {b_mode_q, b_amt_q, (CMPW'(b_r2_q) < CMPW'(c_sum)), (c_sum != '0),
                 b_sgn_q, b_mag_q, b_g_q, b_s_q};
  end

  assign sq_vld[0]  = c_vld_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = c_sum_q;
  assign sq_side[0] = c_side_q;

  generate
    for (genvar i = 0; i < DW; i++) begin : g_sqrt
      vsta_sqrt_cell #(
        .IDX(i), .DW(DW), .SW(SW), .FRAC_BITS(FRAC_BITS), .SIDE_W(SQ_SIDE_W)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .vld_i  (sq_vld[i]),
        .rem_i  (sq_rem[i]),
        .root_i (sq_root[i]),
        .rad_i  (sq_rad[i]),
        .side_i (sq_side[i]),
        .vld_o  (sq_vld[i+1]),
        .rem_o  (sq_rem[i+1]),
        .root_o (sq_root[i+1]),
        .rad_o  (sq_rad[i+1]),
        .side_o (sq_side[i+1])
      );
    end
  endgenerate

  // step length, move decision and visit limit
  always_comb begin
    {e_mode, e_amt, e_far, e_nz, e_sgn, e_mag, e_g, e_s} = sq_side[DW];
    e_rnd = {1'b0, sq_root[DW]} + ((DW+1)'(1) << (FRAC_BITS - 1));
    e_rd  = (STW+1)'(e_rnd[DW:FRAC_BITS]);
    e_ap1 = (STW+1)'(e_amt) + (STW+1)'(1);
    e_moved_d = 1'b0;
    e_step_d  = STW'(1);
    case (e_mode)
      MODE_TOWARD, MODE_AWAY: begin
        e_moved_d = e_nz;
        e_step_d  = (e_amt > AMT_W'(1)) ? STW'(e_amt) : STW'(1);
      end
      MODE_SEEK: begin
        e_moved_d = e_nz && e_far;
        e_step_d  = (e_rd > e_ap1) ? STW'(e_rd - (STW+1)'(e_amt)) : STW'(1);
      end
      default: begin
        e_moved_d = 1'b0;
      end
    endcase
    e_sm1    = e_step_d - STW'(1);
    e_vlim_d = '0;
    if (e_moved_d) begin
      e_vlim_d = (STW'(thr_q) < e_sm1) ? thr_q : e_sm1[THR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    e_moved_q <= e_moved_d;
    e_away_q  <= (e_mode == MODE_AWAY);
    e_step_q  <= e_step_d;
    e_dist_q  <= sq_root[DW];
    e_sum_q   <= sq_rad[DW];
    e_vlim_q  <= e_vlim_d;
    e_sgn_q   <= e_sgn;
    e_mag_q   <= e_mag;
    e_s_q     <= e_s;
    e_g_q     <= e_g;
  end

  // goal reach test and scaled offsets
  assign f_ss = e_step_q * e_step_q;

  always_ff @(posedge clk_i) begin
    f_moved_q <= e_moved_q;
    f_reach_q <= e_moved_q && !e_away_q && (SQW'(f_ss) >= SQW'(e_sum_q));
    f_dist_q  <= e_dist_q;
    f_vlim_q  <= e_vlim_q;
    f_sgn_q   <= e_sgn_q;
    f_s_q     <= e_s_q;
    f_g_q     <= e_g_q;
    for (int k = 0; k < 3; k++) begin
      f_prod_q[k] <= e_mag_q[k] * e_step_q;
    end
  end

  // rounded numerators
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      g_num[k] = (NW'(f_prod_q[k]) << FRAC_BITS) + NW'(f_dist_q >> 1);
    end
  end

  logic                 g_vld_q;
  logic [DW-1:0]        g_dist_q;
  logic [2:0][NW-1:0]   g_num_q;
  logic [DV_SIDE_W-1:0] g_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else begin
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g_dist_q <= f_dist_q;
    g_num_q  <= g_num;
    g_side_q <= {f_vlim_q, f_moved_q, f_reach_q, f_sgn_q, f_g_q, f_s_q};
  end

  assign dv_vld[0]  = g_vld_q;
  assign dv_dvs[0]  = g_dist_q;
  assign dv_num[0]  = g_num_q;
  assign dv_rem[0]  = '0;
  assign dv_quo[0]  = '0;
  assign dv_side[0] = g_side_q;

  generate
    for (genvar i = 0; i < NW; i++) begin : g_div
      vsta_div_cell #(
        .IDX(i), .DW(DW), .NW(NW), .SIDE_W(DV_SIDE_W)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .vld_i  (dv_vld[i]),
        .dvs_i  (dv_dvs[i]),
        .num_i  (dv_num[i]),
        .rem_i  (dv_rem[i]),
        .quo_i  (dv_quo[i]),
        .side_i (dv_side[i]),
        .vld_o  (dv_vld[i+1]),
        .dvs_o  (dv_dvs[i+1]),
        .num_o  (dv_num[i+1]),
        .rem_o  (dv_rem[i+1]),
        .quo_o  (dv_quo[i+1]),
        .side_o (dv_side[i+1])
      );
    end
  endgenerate

  // cap, add, saturate and select
  always_comb begin
    logic [QW-1:0]          qe;
    logic [CAP_SHIFT:0]     cv;
    logic signed [AW-1:0]   off, sum;
    logic signed [AW-1:0]   smax, smin;
    {h_vlim, h_moved, h_reach, h_sgn, h_g, h_s} = dv_side[NW];
    smax = AW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    smin = -smax - AW'(1);
    for (int k = 0; k < 3; k++) begin
      qe  = QW'(dv_quo[NW][k]);
      cv  = (qe > (QW'(1) << CAP_SHIFT)) ? ((CAP_SHIFT+1)'(1) << CAP_SHIFT)
                                         : qe[CAP_SHIFT:0];
      off = h_sgn[k] ? -$signed(AW'(cv)) : $signed(AW'(cv));
      sum = AW'($signed(h_s[k])) + off;
      if (sum > smax) begin
        sum = smax;
      end else if (sum < smin) begin
        sum = smin;
      end
      if (!h_moved) begin
        h_nxt[k] = h_s[k];
      end else if (h_reach) begin
        h_nxt[k] = h_g[k];
      end else begin
        h_nxt[k] = sum[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    moved_q <= h_moved;
    nxt_q   <= h_nxt;
    vlim_q  <= h_vlim;
  end

  assign done_o        = done_q;
  assign moved_o       = moved_q;
  assign next_x_o      = nxt_q[0];
  assign next_y_o      = nxt_q[1];
  assign next_z_o      = nxt_q[2];
  assign visit_limit_o = vlim_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import vsta_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LAT = 2 * CB + 2 * FB + 26 + 9;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam longint COORD_MAX = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint COORD_MIN = -(64'sd1 <<< (CB - 1));
  localparam logic [127:0] OFFSET_LIMIT = 128'd1 << CAP_SHIFT;

  typedef struct packed {
    logic [1:0]           mode;
    logic signed [CB-1:0] sx, sy, sz, gx, gy, gz;
    logic [AMT_W-1:0]     amount;
  } step_item_t;

  typedef struct packed {
    logic                 moved;
    logic signed [CB-1:0] nx, ny, nz;
    logic [THR_W-1:0]     limit;
  } step_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic cfg_we_i = 1'b0;
  logic [THR_W-1:0] cfg_wdata_i = '0;
  logic [1:0] mode_i = '0;
  logic signed [CB-1:0] self_x_i = '0, self_y_i = '0, self_z_i = '0;
  logic signed [CB-1:0] goal_x_i = '0, goal_y_i = '0, goal_z_i = '0;
  logic [AMT_W-1:0] amount_i = '0;
  logic done_o, moved_o;
  logic signed [CB-1:0] next_x_o, next_y_o, next_z_o;
  logic [THR_W-1:0] visit_limit_o;

  step_res_t expected_steps[$];
  logic [THR_W-1:0] model_threshold = '0;
  int err_count = 0;
  int cycle_count = 0;
  int burst_left = 0;

  vector_step_toward_away i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cfg_we_i, .cfg_wdata_i,
    .mode_i, .self_x_i, .self_y_i, .self_z_i, .goal_x_i, .goal_y_i, .goal_z_i,
    .amount_i, .done_o, .moved_o, .next_x_o, .next_y_o, .next_z_o, .visit_limit_o
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // run time limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[vector_step_toward_away] ERROR");
      $finish;
    end
  end

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // expected next position for one item
  function automatic step_res_t predict_step(step_item_t it, logic [THR_W-1:0] thr);
    longint s[3], g[3], d[3], nx[3], mg;
    logic [127:0] sq, rad, cand, num, q;
    logic [63:0] root, rd, step;
    logic moved;
    step_res_t r;
    s[0] = it.sx; s[1] = it.sy; s[2] = it.sz;
    g[0] = it.gx; g[1] = it.gy; g[2] = it.gz;
    sq = '0;
    step = 1;
    moved = 1'b0;
    for (int i = 0; i < 3; i++) begin
      nx[i] = s[i];
      d[i] = (it.mode == MODE_AWAY) ? s[i] - g[i] : g[i] - s[i];
      mg = d[i] < 0 ? -d[i] : d[i];
      sq += 128'(mg) * 128'(mg);
    end
    if (it.mode != MODE_UNUSED && sq != 0) begin
      // truncated root of the distance in fixed point
      rad = sq << (2 * FB);
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = {64'd0, root | (64'd1 << b)};
        if (cand * cand <= rad) root = cand[63:0];
      end
      if (it.mode == MODE_SEEK) begin
        if (128'(it.amount) * 128'(it.amount) < sq) begin
          rd = (root + (64'd1 << (FB - 1))) >> FB;
          step = (rd > 64'(it.amount) + 1) ? rd - 64'(it.amount) : 64'd1;
          moved = 1'b1;
        end
      end else begin
        step = it.amount > 1 ? 64'(it.amount) : 64'd1;
        moved = 1'b1;
      end
      if (moved) begin
        if (it.mode != MODE_AWAY && 128'(step) * 128'(step) >= sq) begin
          for (int i = 0; i < 3; i++) nx[i] = g[i];
        end else begin
          for (int i = 0; i < 3; i++) begin
            mg = d[i] < 0 ? -d[i] : d[i];
            num = ((128'(mg) * 128'(step)) << FB) + 128'(root >> 1);
            q = num / 128'(root);
            if (q > OFFSET_LIMIT) q = OFFSET_LIMIT;
            nx[i] = d[i] < 0 ? s[i] - longint'(q) : s[i] + longint'(q);
          end
        end
      end
    end
    r.moved = moved;
    r.nx = CB'(clamp_coord(nx[0]));
    r.ny = CB'(clamp_coord(nx[1]));
    r.nz = CB'(clamp_coord(nx[2]));
    r.limit = '0;
    if (moved) r.limit = (64'(thr) < step - 1) ? thr : THR_W'(step - 1);
    return r;
  endfunction

  // record accepted transfers and register writes
  always @(posedge clk_i) begin
    step_item_t it;
    if (rst_ni && cfg_we_i) model_threshold <= cfg_wdata_i;
    if (rst_ni && start_i && !busy_o) begin
      it = '{mode_i, self_x_i, self_y_i, self_z_i, goal_x_i, goal_y_i, goal_z_i, amount_i};
      expected_steps.push_back(predict_step(it, model_threshold));
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    err_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    step_res_t e;
    if (rst_ni && done_o) begin
      if (expected_steps.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = expected_steps.pop_front();
        if (moved_o !== e.moved) report_mismatch("moved", moved_o, e.moved);
        if (next_x_o !== e.nx) report_mismatch("next_x", next_x_o, e.nx);
        if (next_y_o !== e.ny) report_mismatch("next_y", next_y_o, e.ny);
        if (next_z_o !== e.nz) report_mismatch("next_z", next_z_o, e.nz);
        if (visit_limit_o !== e.limit) report_mismatch("visit_limit", visit_limit_o, e.limit);
      end
    end
  end

  // send one item, sometimes idling between bursts
  task automatic send_step(step_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i <= 1'b1;
    mode_i <= it.mode;
    self_x_i <= it.sx; self_y_i <= it.sy; self_z_i <= it.sz;
    goal_x_i <= it.gx; goal_y_i <= it.gy; goal_z_i <= it.gz;
    amount_i <= it.amount;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain_pipeline();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_steps.size() != 0) @(posedge clk_i);
    repeat (LAT + 10) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    drain_pipeline();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [CB-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return CB'($urandom);
      1: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      default: return CB'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic step_item_t rand_step();
    step_item_t it;
    int sel;
    sel = $urandom_range(0, 19);
    it.mode = sel == 0 ? MODE_UNUSED : 2'($urandom_range(0, 2));
    it.sx = rand_coord(); it.sy = rand_coord(); it.sz = rand_coord();
    if ($urandom_range(0, 1) != 0) begin
      // goal near self so steps can reach or overshoot it
      it.gx = it.sx + CB'($signed($urandom_range(0, 600)) - 300);
      it.gy = it.sy + CB'($signed($urandom_range(0, 600)) - 300);
      it.gz = it.sz + CB'($signed($urandom_range(0, 600)) - 300);
    end else begin
      it.gx = rand_coord(); it.gy = rand_coord(); it.gz = rand_coord();
    end
    if (sel == 1) begin
      it.gx = it.sx; it.gy = it.sy; it.gz = it.sz;
    end
    case ($urandom_range(0, 2))
      0: it.amount = AMT_W'($urandom);
      1: it.amount = AMT_W'($urandom_range(0, 3));
      default: it.amount = AMT_W'($urandom_range(0, 500));
    endcase
    return it;
  endfunction

  // extremes, every mode and the special cases
  task automatic test_directed();
    send_step('{MODE_TOWARD, 0, 0, 0, 0, 0, 0, 5});
    send_step('{MODE_AWAY, 0, 0, 0, 0, 0, 0, 5});
    send_step('{MODE_SEEK, 0, 0, 0, 0, 0, 0, 0});
    send_step('{MODE_UNUSED, 1, 2, 3, 100, 200, 300, 10});
    send_step('{MODE_TOWARD, 0, 0, 0, 3, 4, 0, 0});
    send_step('{MODE_TOWARD, 0, 0, 0, 3, 4, 0, 5});
    send_step('{MODE_TOWARD, 0, 0, 0, 30, 40, 0, 65535});
    send_step('{MODE_TOWARD, 0, 0, 0, 300, 400, 0, 7});
    send_step('{MODE_AWAY, 0, 0, 0, 3, 4, 0, 1});
    send_step('{MODE_AWAY, 10, -7, 3, 0, 0, 0, 65535});
    send_step('{MODE_SEEK, 0, 0, 0, 3, 4, 0, 5});
    send_step('{MODE_SEEK, 0, 0, 0, 3, 4, 0, 4});
    send_step('{MODE_SEEK, 0, 0, 0, 300, 400, 0, 100});
    send_step('{MODE_TOWARD, COORD_MIN, COORD_MIN, COORD_MIN,
                COORD_MAX, COORD_MAX, COORD_MAX, 65535});
    send_step('{MODE_AWAY, COORD_MAX, COORD_MAX, COORD_MAX,
                COORD_MIN, COORD_MIN, COORD_MIN, 65535});
    send_step('{MODE_AWAY, COORD_MIN, COORD_MAX, COORD_MIN, 0, 0, 0, 65535});
    send_step('{MODE_SEEK, COORD_MIN, COORD_MIN, COORD_MIN,
                COORD_MAX, COORD_MAX, COORD_MAX, 0});
    send_step('{MODE_SEEK, COORD_MAX, 0, 0, COORD_MIN, 0, 0, 65535});
    send_step('{MODE_TOWARD, -1, -1, -1, 1, 1, 1, 1});
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) send_step(rand_step());
  endtask

  // register settings across phases, extremes included
  task automatic test_threshold_phases();
    write_threshold(16'd0);
    test_random(60);
    write_threshold(16'hFFFF);
    test_directed();
    test_random(100);
    write_threshold(16'd1);
    test_random(60);
    write_threshold(THR_W'($urandom_range(2, 300)));
    test_random(100);
    write_threshold(THR_W'($urandom));
    test_random(60);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_threshold_phases();
    drain_pipeline();
    if (err_count == 0) begin
      $display("[vector_step_toward_away] OK");
    end else begin
      $display("[vector_step_toward_away] ERROR");
    end
    $finish;
  end

endmodule
